// ===== design/pid_derivative_on_measurement_assert.svh =====
// Assertion macros used by the top-level design file.
// The clock and active-low reset are passed in so that each use names its own.
`ifndef PID_DERIVATIVE_ON_MEASUREMENT_ASSERT_SVH
`define PID_DERIVATIVE_ON_MEASUREMENT_ASSERT_SVH

`ifndef SYNTHESIS
`define PID_DOM_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("pid_dom assertion failed");
`define PID_DOM_ASSERT_NEVER(lbl, clk, rstn, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) \
    else $error("pid_dom forbidden condition seen");
`else
`define PID_DOM_ASSERT(lbl, clk, rstn, prop)
`define PID_DOM_ASSERT_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// ===== design/pid_dom_pkg.sv =====
package pid_dom_pkg;

  localparam int unsigned DataW = 16;
  localparam int unsigned DiffW = DataW + 1;
  localparam int unsigned ProdW = 2 * DiffW;
  localparam int unsigned AccW  = 28;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CfgIdxW-1:0] CFG_PROP_GAIN  = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_INTEG_GAIN = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_DERIV_GAIN = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT_LOW  = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_LIMIT_HIGH = 3'd4;

  localparam logic signed [DataW-1:0] LIMIT_LOW_RST  = -16'sd8192;
  localparam logic signed [DataW-1:0] LIMIT_HIGH_RST = 16'sd8192;

  typedef struct packed {
    logic        [DataW-1:0] prop_gain;
    logic        [DataW-1:0] integ_gain;
    logic        [DataW-1:0] deriv_gain;
    logic signed [DataW-1:0] limit_low;
    logic signed [DataW-1:0] limit_high;
  } cfg_t;

  typedef struct packed {
    logic signed [DataW-1:0] integral_sum;
    logic signed [DataW-1:0] prev_measured;
  } state_t;

  // Greater-than test first, so inverted limits still give one of the two.
  function automatic logic signed [DataW-1:0] clamp_lim(
    input logic signed [AccW-1:0]  v,
    input logic signed [DataW-1:0] lo,
    input logic signed [DataW-1:0] hi
  );
    logic signed [DataW-1:0] r;
    if (v > hi) begin
      r = hi;
    end else if (v < lo) begin
      r = lo;
    end else begin
      r = v[DataW-1:0];
    end
    return r;
  endfunction

endpackage

// ===== design/pid_dom_in_if.sv =====
interface pid_dom_in_if import pid_dom_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] target;
  logic signed [DataW-1:0] measured;

  modport source (output valid, output target, output measured, input ready);
  modport sink   (input valid, input target, input measured, output ready);
endinterface

// ===== design/pid_dom_out_if.sv =====
interface pid_dom_out_if import pid_dom_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic signed [DataW-1:0] drive;

  modport source (output valid, output drive, input ready);
  modport sink   (input valid, input drive, output ready);
endinterface

// ===== design/pid_dom_core.sv =====
// Single-pass control law: three products, floor to Q2.13 and two clamps.
module pid_dom_core import pid_dom_pkg::*; (
  input  cfg_t                    cfg_i,
  input  state_t                  state_i,
  input  logic signed [DataW-1:0] target_i,
  input  logic signed [DataW-1:0] measured_i,
  output logic signed [DataW-1:0] integral_o,
  output logic signed [DataW-1:0] drive_o
);

  logic signed [DiffW-1:0]   err;
  logic signed [DiffW-1:0]   dmeas;
  logic signed [ProdW-1:0]   ki_prod;
  logic signed [ProdW-1:0]   kp_prod;
  logic signed [ProdW-1:0]   kd_prod;
  logic signed [ProdW:0]     pd_sum;
  logic signed [ProdW-9:0]   ki_floor;
  logic signed [ProdW-8:0]   pd_floor;
  logic signed [ProdW-8:0]   integ_acc;
  logic signed [AccW-1:0]    drive_acc;

  assign err   = DiffW'(target_i) - DiffW'(measured_i);
  assign dmeas = DiffW'(measured_i) - DiffW'(state_i.prev_measured);

  assign ki_prod = $signed({1'b0, cfg_i.integ_gain}) * err;
  assign kp_prod = $signed({1'b0, cfg_i.prop_gain}) * err;
  assign kd_prod = $signed({1'b0, cfg_i.deriv_gain}) * dmeas;

  // Dropping the low eight bits of a two's complement value floors it.
  assign ki_floor = ki_prod[ProdW-1:8];
  assign pd_sum   = (ProdW+1)'(kp_prod) - (ProdW+1)'(kd_prod);
  assign pd_floor = pd_sum[ProdW:8];

  assign integ_acc  = (ProdW-7)'(state_i.integral_sum) + (ProdW-7)'(ki_floor);
  assign integral_o = clamp_lim(AccW'(integ_acc), cfg_i.limit_low, cfg_i.limit_high);

  assign drive_acc = AccW'(pd_floor) + AccW'(integral_o);
  assign drive_o   = clamp_lim(drive_acc, cfg_i.limit_low, cfg_i.limit_high);

endmodule

// ===== design/pid_derivative_on_measurement.sv =====
// Channel   Role    Payload                          Transfer when
// in_ch     sink    target, measured (Q2.13 signed)  valid && ready
// out_ch    source  drive (Q2.13 signed)             valid && ready
//
// A transfer on in_ch is held in an input register; the control law is then
// evaluated on it in one combinational pass and the drive lands in the result
// register, which out_ch presents until the drive is taken.
// One item is taken every cycle while out_ch is not stalled; a stall holds the
// result and the waiting input, and in_ch takes items again once out_ch moves.
// Reset clears the gains, sets the limits to -1.0 and +1.0 and zeroes the state.
`include "pid_derivative_on_measurement_assert.svh"

module pid_derivative_on_measurement import pid_dom_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [DataW-1:0]   cfg_wdata_i,
  pid_dom_in_if.sink         in_ch,
  pid_dom_out_if.source      out_ch
);

  cfg_t   cfg_q;
  state_t state_q;
  state_t state_d;

  logic signed [DataW-1:0] integral_d;

  logic                    in_vld_q;
  logic signed [DataW-1:0] target_q;
  logic signed [DataW-1:0] measured_q;

  logic                    out_vld_q;
  logic signed [DataW-1:0] drive_q;
  logic signed [DataW-1:0] drive_d;

  logic in_xfer;
  logic advance;

  // The held item moves to the result register when that register is free
  // or is being emptied in this cycle.
  assign advance      = in_vld_q && (!out_vld_q || out_ch.ready);
  assign in_ch.ready  = !in_vld_q || advance;
  assign in_xfer      = in_ch.valid && in_ch.ready;
  assign out_ch.valid = out_vld_q;
  assign out_ch.drive = drive_q;

  // Configuration registers; indexes beyond the list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.prop_gain  <= '0;
      cfg_q.integ_gain <= '0;
      cfg_q.deriv_gain <= '0;
      cfg_q.limit_low  <= LIMIT_LOW_RST;
      cfg_q.limit_high <= LIMIT_HIGH_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PROP_GAIN:  cfg_q.prop_gain  <= cfg_wdata_i;
        CFG_INTEG_GAIN: cfg_q.integ_gain <= cfg_wdata_i;
        CFG_DERIV_GAIN: cfg_q.deriv_gain <= cfg_wdata_i;
        CFG_LIMIT_LOW:  cfg_q.limit_low  <= $signed(cfg_wdata_i);
        CFG_LIMIT_HIGH: cfg_q.limit_high <= $signed(cfg_wdata_i);
        default: ;
      endcase
    end
  end

  pid_dom_core u_core (
    .cfg_i      (cfg_q),
    .state_i    (state_q),
    .target_i   (target_q),
    .measured_i (measured_q),
    .integral_o (integral_d),
    .drive_o    (drive_d)
  );

  assign state_d = '{integral_sum: integral_d, prev_measured: measured_q};

  // Controller state changes only when an item completes its pass.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      target_q   <= in_ch.target;
      measured_q <= in_ch.measured;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (advance) begin
      out_vld_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      drive_q <= drive_d;
    end
  end

  // in_ch may only be held off while both registers are full and stalled.
  `PID_DOM_ASSERT_NEVER(a_ready_low_only_when_full, clk_i, rst_ni,
    !in_ch.ready && !(in_vld_q && out_vld_q && !out_ch.ready))
  `PID_DOM_ASSERT(a_advance_fills_output, clk_i, rst_ni, advance |=> out_vld_q)
  `PID_DOM_ASSERT(a_state_holds_when_idle, clk_i, rst_ni,
    !advance |=> $stable(state_q))
  `PID_DOM_ASSERT(a_prev_meas_tracks_item, clk_i, rst_ni,
    advance |=> (state_q.prev_measured == $past(measured_q)))

endmodule
